### hw/rtl/ftts_pkg.sv
// ----------------------------------------------------------------------------
// ftts_pkg
// Shared constants and controller/datapath handshake types for the
// frame timer fixed-tick scheduler.
// ----------------------------------------------------------------------------
package ftts_pkg;

  localparam int FIELD_W  = 48;
  localparam int RATE_W   = 20;
  localparam int FRAMES_W = 32;

  localparam logic [RATE_W-1:0] ONE_SECOND_US = 20'd1000000;
  localparam logic [RATE_W-1:0] RATE_RESET    = 20'd60;

  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic MUL_SEL_NEXT_TICK = 1'b0;  // (ticks + 1) * 1e6
  localparam logic MUL_SEL_ELAPSED   = 1'b1;  // elapsed * rate
  localparam logic DIV_SEL_FRAME     = 1'b0;  // span / frames
  localparam logic DIV_SEL_TICK      = 1'b1;  // product / rate

  typedef struct packed {
    logic capture;
    logic frame_first;
    logic frame_next;
    logic window_close;
    logic avg_sat;
    logic mul_start;
    logic mul_sel;
    logic save_p1;
    logic div_start;
    logic div_sel;
    logic tick_commit;
    logic tick_time_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic span_ge;
    logic frames_zero;
    logic tick_blocked;
    logic p_le;
    logic mul_busy;
    logic div_busy;
  } status_t;

endpackage

### hw/rtl/ftts_if.sv
// ----------------------------------------------------------------------------
// ftts_if
// Valid/ready channels of the scheduler: request, response and rate write.
// ----------------------------------------------------------------------------
interface ftts_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ftts_pkg::FIELD_W-1:0] timestamp_us;

  modport source (output valid, output mode, output timestamp_us, input ready);
  modport sink   (input valid, input mode, input timestamp_us, output ready);
endinterface

interface ftts_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         tick_fired;
  logic [ftts_pkg::FIELD_W-1:0] tick_count;
  logic [ftts_pkg::FIELD_W-1:0] tick_time_us;
  logic [ftts_pkg::FIELD_W-1:0] elapsed_us;
  logic [ftts_pkg::FIELD_W-1:0] avg_frame_us;

  modport source (output valid, output tick_fired, output tick_count,
                  output tick_time_us, output elapsed_us, output avg_frame_us,
                  input ready);
  modport sink   (input valid, input tick_fired, input tick_count,
                  input tick_time_us, input elapsed_us, input avg_frame_us,
                  output ready);
endinterface

interface ftts_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ftts_pkg::RATE_W-1:0] ticks_per_second;

  modport source (output valid, output ticks_per_second, input ready);
  modport sink   (input valid, input ticks_per_second, output ready);
endinterface

### hw/rtl/ftts_dp.sv
// ----------------------------------------------------------------------------
// ftts_dp
// Datapath: timing state, shift-add multiplier, restoring divider and the
// response register.
// ----------------------------------------------------------------------------
module ftts_dp #(
  parameter int TIME_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ftts_pkg::cmd_t                cmd,
  input  logic [ftts_pkg::FIELD_W-1:0]  timestamp_us,
  input  logic                          cfg_we,
  input  logic [ftts_pkg::RATE_W-1:0]   cfg_rate,
  output ftts_pkg::status_t             status,
  output logic                          tick_fired,
  output logic [ftts_pkg::FIELD_W-1:0]  tick_count,
  output logic [ftts_pkg::FIELD_W-1:0]  tick_time_us,
  output logic [ftts_pkg::FIELD_W-1:0]  elapsed_us,
  output logic [ftts_pkg::FIELD_W-1:0]  avg_frame_us
);

  localparam int FW     = ftts_pkg::FIELD_W;
  localparam int RW     = ftts_pkg::RATE_W;
  localparam int NW     = ftts_pkg::FRAMES_W;
  localparam int W      = TIME_BITS + RW;
  localparam int MUL_CW = $clog2(RW);
  localparam int DIV_CW = $clog2(W);
  localparam logic [MUL_CW-1:0]    MUL_LAST  = MUL_CW'(RW - 1);
  localparam logic [DIV_CW-1:0]    DIV_LAST  = DIV_CW'(W - 1);
  localparam logic [TIME_BITS-1:0] TIME_ONES = '1;
  localparam logic [TIME_BITS-1:0] SECOND_T  = TIME_BITS'(ftts_pkg::ONE_SECOND_US);

  function automatic logic [FW-1:0] to_field(input logic [TIME_BITS-1:0] v);
    logic [TIME_BITS+FW-1:0] w;
    w = {{FW{1'b0}}, v};
    return w[FW-1:0];
  endfunction

  // timing state
  logic [RW-1:0]        rate;
  logic                 started;
  logic [TIME_BITS-1:0] origin_time;
  logic [TIME_BITS-1:0] elapsed_time;
  logic [TIME_BITS-1:0] window_mark;
  logic [NW-1:0]        window_frames;
  logic [TIME_BITS-1:0] average_frame;
  logic [TIME_BITS-1:0] ticks_issued;
  logic [TIME_BITS-1:0] tick_time;
  logic                 fired;

  logic [TIME_BITS-1:0]    ts;
  logic [TIME_BITS+FW-1:0] ts_wide;
  logic [TIME_BITS-1:0]    span;

  // multiplier
  logic [W-1:0]      acc;
  logic [W-1:0]      mcand;
  logic [RW-1:0]     mplier;
  logic [MUL_CW-1:0] mul_cnt;
  logic              mul_busy;
  logic [W-1:0]      p1;

  // divider
  logic [W-1:0]      dq;
  logic [NW-1:0]     dvs;
  logic [NW-1:0]     rem;
  logic [DIV_CW-1:0] div_cnt;
  logic              div_busy;
  logic [NW:0]       trial;
  logic [NW:0]       diff;
  logic              trial_ge;

  assign ts_wide  = {{TIME_BITS{1'b0}}, timestamp_us};
  assign span     = elapsed_time - window_mark;
  assign trial    = {rem, dq[W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign trial_ge = trial >= {1'b0, dvs};

  always_comb begin
    status.started      = started;
    status.span_ge      = span >= SECOND_T;
    status.frames_zero  = window_frames == '0;
    status.tick_blocked = (rate == '0) || (ticks_issued == TIME_ONES);
    status.p_le         = p1 <= acc;
    status.mul_busy     = mul_busy;
    status.div_busy     = div_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= ftts_pkg::RATE_RESET;
    end else if (cfg_we) begin
      rate <= cfg_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ts <= ts_wide[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      origin_time   <= '0;
      elapsed_time  <= '0;
      window_mark   <= '0;
      window_frames <= '0;
      average_frame <= '0;
      ticks_issued  <= '0;
      tick_time     <= '0;
      fired         <= 1'b0;
    end else begin
      if (cmd.capture) begin
        fired <= 1'b0;
      end
      if (cmd.frame_first) begin
        started      <= 1'b1;
        origin_time  <= ts;
        elapsed_time <= '0;
        tick_time    <= '0;
      end
      if (cmd.frame_next) begin
        elapsed_time  <= ts - origin_time;
        window_frames <= window_frames + NW'(1);
      end
      if (cmd.window_close) begin
        window_mark   <= elapsed_time;
        window_frames <= '0;
        average_frame <= cmd.avg_sat ? TIME_ONES : dq[TIME_BITS-1:0];
      end
      if (cmd.tick_commit) begin
        ticks_issued <= ticks_issued + TIME_BITS'(1);
        fired        <= 1'b1;
      end
      if (cmd.tick_time_write) begin
        tick_time <= dq[TIME_BITS-1:0];
      end
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy <= 1'b1;
    end else if (mul_busy && mul_cnt == MUL_LAST) begin
      mul_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      acc     <= '0;
      mul_cnt <= '0;
      if (cmd.mul_sel == ftts_pkg::MUL_SEL_ELAPSED) begin
        mcand  <= {{RW{1'b0}}, elapsed_time};
        mplier <= rate;
      end else begin
        mcand  <= {{RW{1'b0}}, ticks_issued + TIME_BITS'(1)};
        mplier <= ftts_pkg::ONE_SECOND_US;
      end
    end else if (mul_busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand   <= {mcand[W-2:0], 1'b0};
      mplier  <= {1'b0, mplier[RW-1:1]};
      mul_cnt <= mul_cnt + MUL_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_p1) begin
      p1 <= acc;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == DIV_LAST) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= '0;
      div_cnt <= '0;
      if (cmd.div_sel == ftts_pkg::DIV_SEL_TICK) begin
        dq  <= p1;
        dvs <= NW'(rate);
      end else begin
        dq  <= {{RW{1'b0}}, span};
        dvs <= window_frames;
      end
    end else if (div_busy) begin
      rem     <= trial_ge ? diff[NW-1:0] : trial[NW-1:0];
      dq      <= {dq[W-2:0], trial_ge};
      div_cnt <= div_cnt + DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tick_fired   <= fired;
      tick_count   <= to_field(ticks_issued);
      tick_time_us <= to_field(tick_time);
      elapsed_us   <= to_field(elapsed_time);
      avg_frame_us <= to_field(average_frame);
    end
  end

endmodule

### hw/rtl/ftts_ctrl.sv
// ----------------------------------------------------------------------------
// ftts_ctrl
// Sequencer: walks one item through frame or tick handling and owns the
// request/response handshakes.
// ----------------------------------------------------------------------------
module ftts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              req_mode,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  ftts_pkg::status_t status,
  output ftts_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FRAME = 4'd1;
  localparam logic [3:0] S_FCHK  = 4'd2;
  localparam logic [3:0] S_FDIV  = 4'd3;
  localparam logic [3:0] S_TCHK  = 4'd4;
  localparam logic [3:0] S_TMUL1 = 4'd5;
  localparam logic [3:0] S_TMUL2 = 4'd6;
  localparam logic [3:0] S_TCMP  = 4'd7;
  localparam logic [3:0] S_TDIV  = 4'd8;
  localparam logic [3:0] S_WB    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid;
  logic       out_valid_next;

  assign req_ready = state == S_IDLE;
  assign rsp_valid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = (req_mode == ftts_pkg::MODE_TICK) ? S_TCHK : S_FRAME;
        end
      end
      S_FRAME: begin
        if (!status.started) begin
          cmd.frame_first = 1'b1;
          state_next      = S_WB;
        end else begin
          cmd.frame_next = 1'b1;
          state_next     = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!status.span_ge) begin
          state_next = S_WB;
        end else if (status.frames_zero) begin
          // frame counter wrapped: average saturates
          cmd.window_close = 1'b1;
          cmd.avg_sat      = 1'b1;
          state_next       = S_WB;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = ftts_pkg::DIV_SEL_FRAME;
          state_next    = S_FDIV;
        end
      end
      S_FDIV: begin
        if (!status.div_busy) begin
          cmd.window_close = 1'b1;
          state_next       = S_WB;
        end
      end
      S_TCHK: begin
        if (status.tick_blocked) begin
          state_next = S_WB;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = ftts_pkg::MUL_SEL_NEXT_TICK;
          state_next    = S_TMUL1;
        end
      end
      S_TMUL1: begin
        if (!status.mul_busy) begin
          cmd.save_p1   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = ftts_pkg::MUL_SEL_ELAPSED;
          state_next    = S_TMUL2;
        end
      end
      S_TMUL2: begin
        if (!status.mul_busy) begin
          state_next = S_TCMP;
        end
      end
      S_TCMP: begin
        if (status.p_le) begin
          // saved product is (new tick count) * 1e6: divide it by the rate
          cmd.tick_commit = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_sel     = ftts_pkg::DIV_SEL_TICK;
          state_next      = S_TDIV;
        end else begin
          state_next = S_WB;
        end
      end
      S_TDIV: begin
        if (!status.div_busy) begin
          cmd.tick_time_write = 1'b1;
          state_next          = S_WB;
        end
      end
      S_WB: begin
        if (!out_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/frame_timer_fixed_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// frame_timer_fixed_tick_scheduler_core
// Frame timing and fixed-rate tick scheduling, one response per request.
// ----------------------------------------------------------------------------
// Each request is a frame (mode 0, with an absolute microsecond timestamp) or
// a tick request (mode 1); each produces one response with the tick flag and
// the current tick count, tick time, elapsed time and one-second average frame
// time. One request is processed at a time. A frame is answered after the
// window check (the first frame skips it), and also after a divide of the
// span by the frame count when it closes a window and the average is divided
// out. A tick request answers without a multiply when the rate is zero or the
// counter is full, after two shift-add multiplies when the exact fire test
// fails, and when it fires after those two shift-add multiplies for the exact
// fire test, then a one-bit-per-cycle divide of a (TIME_BITS + 20)-bit product
// by the rate. The next request is accepted in the cycle after the response
// is loaded into the output register; a response still waiting there holds
// the block in its last step. ticks_per_second may be written at any time the
// block is idle and is always ready.
module frame_timer_fixed_tick_scheduler_core #(
  parameter int TIME_BITS = 48
) (
  input logic       clk,
  input logic       rst,
  ftts_req_if.sink   req,
  ftts_rsp_if.source rsp,
  ftts_cfg_if.sink   cfg
);

  ftts_pkg::cmd_t    cmd;
  ftts_pkg::status_t status;
  logic              req_ready;
  logic              rsp_valid;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign cfg.ready = 1'b1;

  ftts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .req_mode  (req.mode),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ftts_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .timestamp_us (req.timestamp_us),
    .cfg_we       (cfg.valid),
    .cfg_rate     (cfg.ticks_per_second),
    .status       (status),
    .tick_fired   (rsp.tick_fired),
    .tick_count   (rsp.tick_count),
    .tick_time_us (rsp.tick_time_us),
    .elapsed_us   (rsp.elapsed_us),
    .avg_frame_us (rsp.avg_frame_us)
  );

endmodule

### hw/rtl/ftts_checker.sv
// ----------------------------------------------------------------------------
// ftts_checker
// Port-level checks for the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module ftts_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         tick_fired,
  input logic [ftts_pkg::FIELD_W-1:0] tick_count,
  input logic [ftts_pkg::FIELD_W-1:0] tick_time_us,
  input logic [ftts_pkg::FIELD_W-1:0] elapsed_us
);

  // one request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // a fired tick never lies past the elapsed time
  a_tick_not_late: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && tick_fired |-> tick_time_us <= elapsed_us && tick_count != '0)
    else $error("fired tick ahead of elapsed time");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(tick_count) &&
                                $stable(tick_fired))
    else $error("stalled response changed");

  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind frame_timer_fixed_tick_scheduler_core ftts_checker u_ftts_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .tick_fired   (rsp.tick_fired),
  .tick_count   (rsp.tick_count),
  .tick_time_us (rsp.tick_time_us),
  .elapsed_us   (rsp.elapsed_us)
);
